FILE: hdl/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared constants for the heightmap bilinear sampler: field widths,
// configuration register indexes and operation codes.
// ----------------------------------------------------------------------------
package hbs_pkg;

  // fixed field widths
  localparam int POS_W    = 16;
  localparam int HEIGHT_W = 16;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_ROWS    = 1'd1;

  // operation codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

endpackage

FILE: hdl/hbs_ram.sv
// ----------------------------------------------------------------------------
// hbs_ram
// Generic single-port RAM with one write or read per cycle and registered
// read data.
// ----------------------------------------------------------------------------
module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/heightmap_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler
// Vertex height grid with integer-position writes and bilinear sampling at
// fixed-point positions; vertices outside the configured grid read as zero.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | func, pos_x, pos_y, height_in
//  out      | out_valid / out_stall| height_out, point_inside
//  cfg      | cfg_write            | cfg_index, cfg_data
//
//  A write passes S_BASE and S_WR, a sample S_BASE, then S_RD and S_MAC per
//  vertex: one shared multiplier and the single-port height memory handle the
//  four vertices in turn (read and weight, then multiply-accumulate).
//  After reset all GRID_SIDE*GRID_SIDE memory words (65536 at the default)
//  are swept to zero, with in_stall held high; config writes still land.
//  A finished result waits in the output register while the next item is
//  taken; the sequencer waits in S_DONE only when a second result is ready.
//
module heightmap_bilinear_sampler #(
  parameter int GRID_SIDE = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbs_pkg::CFG_W-1:0]      cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [hbs_pkg::POS_W-1:0]      pos_x,
  input  logic [hbs_pkg::POS_W-1:0]      pos_y,
  input  logic signed [hbs_pkg::HEIGHT_W-1:0] height_in,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [hbs_pkg::HEIGHT_W-1:0] height_out,
  output logic                           point_inside
);

  localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int XW     = hbs_pkg::POS_W - FRAC_BITS;
  localparam int CW     = (XW + 1 > hbs_pkg::CFG_W) ? XW + 1 : hbs_pkg::CFG_W;
  localparam int OA_W   = hbs_pkg::HEIGHT_W + 1;
  localparam int WGT_W  = 2 * FRAC_BITS + 2;
  localparam int MUL_W  = OA_W + WGT_W;
  localparam int ACC_W  = 2 * FRAC_BITS + 18;
  localparam int HW     = hbs_pkg::HEIGHT_W;

  localparam logic [FRAC_BITS:0]         ONE      = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [hbs_pkg::CFG_W-1:0]  SIDE_LIM = hbs_pkg::CFG_W'(GRID_SIDE);
  localparam logic [AW-1:0]              LAST_ADDR = AW'(DEPTH - 1);

  // sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_BASE = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_MAC  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]                     state;
  logic [AW-1:0]                  clr_addr;
  logic [hbs_pkg::CFG_W-1:0]      vertex_columns;
  logic [hbs_pkg::CFG_W-1:0]      vertex_rows;
  logic [hbs_pkg::CFG_W-1:0]      lim_c;
  logic [hbs_pkg::CFG_W-1:0]      lim_r;

  logic                           func_r;
  logic [XW-1:0]                  x_r;
  logic [XW-1:0]                  y_r;
  logic [FRAC_BITS-1:0]           u_r;
  logic [FRAC_BITS-1:0]           v_r;
  logic [HW-1:0]                  hin_r;
  logic [AW-1:0]                  base;
  logic                           base_inside;
  logic [1:0]                     k;
  logic                           vtx_inside;
  logic signed [WGT_W-1:0]        wgt;
  logic signed [ACC_W-1:0]        acc;

  logic                           ram_we;
  logic [AW-1:0]                  ram_addr;
  logic [HW-1:0]                  ram_wdata;
  logic [HW-1:0]                  ram_rdata;

  logic signed [OA_W-1:0]         op_a;
  logic signed [WGT_W-1:0]        op_b;
  logic signed [MUL_W-1:0]        mul;
  logic [CW-1:0]                  xk;
  logic [CW-1:0]                  yk;
  logic                           k_inside;
  logic                           xy_inside;
  logic [FRAC_BITS:0]             wx;
  logic [FRAC_BITS:0]             wy;
  logic [AW-1:0]                  off;
  logic signed [HW-1:0]           h_sel;
  logic                           out_free;

  // register limits saturate at the grid side
  assign lim_c = (vertex_columns > SIDE_LIM) ? SIDE_LIM : vertex_columns;
  assign lim_r = (vertex_rows > SIDE_LIM) ? SIDE_LIM : vertex_rows;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_columns <= '0;
      vertex_rows    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hbs_pkg::REG_VERTEX_COLUMNS: vertex_columns <= cfg_data;
        hbs_pkg::REG_VERTEX_ROWS:    vertex_rows    <= cfg_data;
        default: ;
      endcase
    end
  end

  // neighbour vertex k and its grid check
  assign xk        = CW'(x_r) + CW'(k[0]);
  assign yk        = CW'(y_r) + CW'(k[1]);
  assign k_inside  = (xk < CW'(lim_c)) && (yk < CW'(lim_r));
  assign xy_inside = (CW'(x_r) < CW'(lim_c)) && (CW'(y_r) < CW'(lim_r));

  // bilinear weight factors
  assign wx = k[0] ? {1'b0, u_r} : ONE - {1'b0, u_r};
  assign wy = k[1] ? {1'b0, v_r} : ONE - {1'b0, v_r};

  // memory offset of vertex k from the base vertex
  always_comb begin
    unique case (k)
      2'd0:    off = '0;
      2'd1:    off = AW'(1);
      2'd2:    off = AW'(lim_c);
      default: off = AW'(lim_c) + AW'(1);
    endcase
  end

  // out-of-grid vertices read as zero
  assign h_sel = vtx_inside ? $signed(ram_rdata) : '0;

  // shared multiplier operand selection
  always_comb begin
    unique case (state)
      S_BASE: begin
        op_a = $signed(OA_W'(y_r));
        op_b = $signed(WGT_W'(lim_c));
      end
      S_RD: begin
        op_a = $signed(OA_W'(wx));
        op_b = $signed(WGT_W'(wy));
      end
      S_MAC: begin
        op_a = OA_W'(h_sel);
        op_b = wgt;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul = MUL_W'(op_a) * MUL_W'(op_b);

  // memory port selection
  always_comb begin
    unique case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      S_WR: begin
        ram_we    = base_inside;
        ram_addr  = base;
        ram_wdata = hin_r;
      end
      S_RD: begin
        ram_we    = 1'b0;
        ram_addr  = base + off;
        ram_wdata = hin_r;
      end
      default: begin
        ram_we    = 1'b0;
        ram_addr  = base;
        ram_wdata = hin_r;
      end
    endcase
  end

  hbs_ram #(
    .WIDTH (HW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      k        <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_BASE;
          end
        end
        S_BASE: begin
          k     <= '0;
          state <= (func_r == hbs_pkg::FUNC_WRITE) ? S_WR : S_RD;
        end
        S_WR: begin
          state <= S_DONE;
        end
        S_RD: begin
          state <= S_MAC;
        end
        S_MAC: begin
          k     <= k + 2'd1;
          state <= (k == 2'd3) ? S_DONE : S_RD;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        func_r <= func;
        x_r    <= pos_x[hbs_pkg::POS_W-1:FRAC_BITS];
        y_r    <= pos_y[hbs_pkg::POS_W-1:FRAC_BITS];
        u_r    <= pos_x[FRAC_BITS-1:0];
        v_r    <= pos_y[FRAC_BITS-1:0];
        hin_r  <= height_in;
        acc    <= '0;
      end
      S_BASE: begin
        base        <= AW'(mul) + AW'(x_r);
        base_inside <= xy_inside;
      end
      S_RD: begin
        wgt        <= WGT_W'(mul);
        vtx_inside <= k_inside;
      end
      S_MAC: begin
        acc <= acc + ACC_W'(mul);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      height_out   <= HW'(acc >>> (2 * FRAC_BITS));
      point_inside <= base_inside;
    end
  end

endmodule

FILE: tb/heightmap_bilinear_sampler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_tb
// Self-checking bench for the heightmap sampler. Vertex writes and bilinear
// samples are driven over the valid/stall input channel under several grid
// sizes, including empty and oversized ones. A grid model inside the
// scoreboard predicts every result, and each result is checked in order.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_tb;

  // one input transfer
  typedef struct {
    logic                                op;
    logic [hbs_pkg::POS_W-1:0]           px;
    logic [hbs_pkg::POS_W-1:0]           py;
    logic signed [hbs_pkg::HEIGHT_W-1:0] h;
  } grid_op_t;

  // one expected result
  typedef struct {
    logic signed [hbs_pkg::HEIGHT_W-1:0] height;
    logic                                in_grid;
  } grid_reply_t;

  // grid model plus queue of predicted heights
  class height_blend_scoreboard_t;
    bit signed [hbs_pkg::HEIGHT_W-1:0] heights [65536];
    int unsigned columns;
    int unsigned rows;
    grid_reply_t pending_heights [$];
    int errors;

    function new();
      columns = 0;
      rows    = 0;
      errors  = 0;
    endfunction

    function void set_register(logic [hbs_pkg::CFG_IDX_W-1:0] idx,
                               logic [hbs_pkg::CFG_W-1:0] val);
      if (idx == hbs_pkg::REG_VERTEX_COLUMNS) columns = 32'(val);
      else if (idx == hbs_pkg::REG_VERTEX_ROWS) rows = 32'(val);
    endfunction

    function int unsigned eff_cols();
      return (columns > 256) ? 256 : columns;
    endfunction

    function int unsigned eff_rows();
      return (rows > 256) ? 256 : rows;
    endfunction

    function bit is_in_grid(int unsigned x, int unsigned y);
      return (x < eff_cols()) && (y < eff_rows());
    endfunction

    function int unsigned slot(int unsigned x, int unsigned y);
      return (y * eff_cols() + x) & 32'hFFFF;
    endfunction

    // vertices outside the grid read as zero
    function longint vertex_height(int unsigned x, int unsigned y);
      if (!is_in_grid(x, y)) return 0;
      return longint'(heights[slot(x, y)]);
    endfunction

    function void note_item(grid_op_t t);
      int unsigned x, y;
      longint u, v, a, b, c, d, sum;
      grid_reply_t r;
      x = 32'(t.px[15:8]);
      y = 32'(t.py[15:8]);
      u = longint'(t.px[7:0]);
      v = longint'(t.py[7:0]);
      r.in_grid = is_in_grid(x, y);
      if (t.op == hbs_pkg::FUNC_WRITE) begin
        if (r.in_grid) heights[slot(x, y)] = t.h;
        r.height = '0;
      end else begin
        a = vertex_height(x, y);
        b = vertex_height(x + 1, y);
        c = vertex_height(x, y + 1);
        d = vertex_height(x + 1, y + 1);
        sum = a * (256 - u) * (256 - v) + b * u * (256 - v)
            + c * (256 - u) * v + d * u * v;
        // arithmetic shift floors the 16 fraction bits
        sum = sum >>> 16;
        r.height = sum[15:0];
      end
      pending_heights.push_back(r);
    endfunction

    function void check_result(logic signed [hbs_pkg::HEIGHT_W-1:0] height,
                               logic in_grid);
      grid_reply_t e;
      if (pending_heights.size() == 0) begin
        $error("result with nothing expected: height_out=%h point_inside=%b",
               height, in_grid);
        errors++;
        return;
      end
      e = pending_heights.pop_front();
      if (height !== e.height) begin
        $error("height_out mismatch: expected %h, actual %h", e.height, height);
        errors++;
      end
      if (in_grid !== e.in_grid) begin
        $error("point_inside mismatch: expected %b, actual %b", e.in_grid, in_grid);
        errors++;
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst;
  logic                                cfg_write;
  logic [hbs_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [hbs_pkg::CFG_W-1:0]           cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic                                func;
  logic [hbs_pkg::POS_W-1:0]           pos_x;
  logic [hbs_pkg::POS_W-1:0]           pos_y;
  logic signed [hbs_pkg::HEIGHT_W-1:0] height_in;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [hbs_pkg::HEIGHT_W-1:0] height_out;
  logic                                point_inside;

  height_blend_scoreboard_t grid_model;
  bit calm;
  int unsigned out_hold;

  heightmap_bilinear_sampler u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .height_in    (height_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .height_out   (height_out),
    .point_inside (point_inside)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // overall time limit
  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

  // mostly short gaps, a few long ones, none in calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stall pattern
  initial begin
    out_stall = 1'b0;
    out_hold  = 0;
    forever begin
      @(negedge clk);
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_hold = pick_gap();
        if (out_hold > 0) begin
          out_hold--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      grid_model.check_result(height_out, point_inside);
  end

  // one transfer on the input channel, entered and left at a falling edge
  task automatic send(logic op, logic [hbs_pkg::POS_W-1:0] px,
                      logic [hbs_pkg::POS_W-1:0] py,
                      logic signed [hbs_pkg::HEIGHT_W-1:0] h);
    grid_op_t t;
    int unsigned gap;
    t.op = op;
    t.px = px;
    t.py = py;
    t.h  = h;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    func      <= op;
    pos_x     <= px;
    pos_y     <= py;
    height_in <= h;
    do @(posedge clk); while (in_stall);
    grid_model.note_item(t);
    @(negedge clk);
  endtask

  // wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (grid_model.pending_heights.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // both grid registers, back to back
  task automatic set_grid(logic [hbs_pkg::CFG_W-1:0] cols,
                          logic [hbs_pkg::CFG_W-1:0] nrows);
    cfg_write <= 1'b1;
    cfg_index <= hbs_pkg::REG_VERTEX_COLUMNS;
    cfg_data  <= cols;
    @(posedge clk);
    grid_model.set_register(hbs_pkg::REG_VERTEX_COLUMNS, cols);
    @(negedge clk);
    cfg_index <= hbs_pkg::REG_VERTEX_ROWS;
    cfg_data  <= nrows;
    @(posedge clk);
    grid_model.set_register(hbs_pkg::REG_VERTEX_ROWS, nrows);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // coordinate near a window of the grid, sometimes anywhere
  function automatic logic [hbs_pkg::POS_W-1:0] pick_coord(int unsigned base,
                                                           int unsigned span);
    int unsigned whole;
    logic [7:0] frac;
    int unsigned r;
    if ($urandom_range(0, 99) < 12) return hbs_pkg::POS_W'($urandom);
    whole = base + $urandom_range(0, span);
    if (whole > 255) whole = 255;
    r = $urandom_range(0, 9);
    frac = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
    return {whole[7:0], frac};
  endfunction

  function automatic logic signed [hbs_pkg::HEIGHT_W-1:0] pick_height();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'sh7FFF;
    if (r < 16) return 16'sh8000;
    return hbs_pkg::HEIGHT_W'($urandom);
  endfunction

  // stimulus
  initial begin
    int unsigned phase_cols [8];
    int unsigned phase_rows [8];
    int unsigned cols, nrows, ec, er, span_x, span_y, base_x, base_y;

    phase_cols = '{256, 511, 1, 2, 17, 0, 9, 300};
    phase_rows = '{256, 300, 1, 7, 3, 9, 0, 256};
    grid_model = new();
    calm      = 1'b1;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    func      = hbs_pkg::FUNC_WRITE;
    pos_x     = '0;
    pos_y     = '0;
    height_in = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: small 3 x 2 grid, extremes, edges and outside vertices
    @(negedge clk);
    set_grid(3, 2);
    send(hbs_pkg::FUNC_WRITE,  16'h0000, 16'h0000, 16'sh7FFF);
    send(hbs_pkg::FUNC_WRITE,  16'h01FF, 16'h00AB, 16'sh8000);
    send(hbs_pkg::FUNC_WRITE,  16'h0200, 16'h0100, 16'sh1234);
    send(hbs_pkg::FUNC_WRITE,  16'h0100, 16'h0100, 16'shFF80);
    send(hbs_pkg::FUNC_WRITE,  16'h0300, 16'h0000, 16'sh5555);
    send(hbs_pkg::FUNC_WRITE,  16'h0000, 16'h0200, 16'sh2222);
    send(hbs_pkg::FUNC_SAMPLE, 16'h0000, 16'h0000, 16'sh0000);
    send(hbs_pkg::FUNC_SAMPLE, 16'h00FF, 16'h00FF, 16'shFFFF);
    send(hbs_pkg::FUNC_SAMPLE, 16'h0180, 16'h0080, 16'sh0000);
    send(hbs_pkg::FUNC_SAMPLE, 16'h0280, 16'h0180, 16'sh0000);
    send(hbs_pkg::FUNC_SAMPLE, 16'h0100, 16'h0100, 16'sh0000);
    send(hbs_pkg::FUNC_SAMPLE, 16'hFFFF, 16'hFFFF, 16'sh7FFF);
    drain();
    // empty grid: writes dropped, samples read zero
    set_grid(0, 2);
    send(hbs_pkg::FUNC_WRITE,  16'h0000, 16'h0000, 16'sh1111);
    send(hbs_pkg::FUNC_SAMPLE, 16'h0080, 16'h0080, 16'sh0000);
    drain();
    // wider rows: stored data stays put, indexes shift
    set_grid(4, 2);
    send(hbs_pkg::FUNC_SAMPLE, 16'h0080, 16'h0080, 16'sh0000);
    send(hbs_pkg::FUNC_SAMPLE, 16'h0300, 16'h0000, 16'sh0000);
    drain();
    // registers above the grid side saturate
    set_grid(511, 511);
    send(hbs_pkg::FUNC_WRITE,  16'hFF00, 16'hFF00, 16'sh7FFF);
    send(hbs_pkg::FUNC_WRITE,  16'hFEFF, 16'hFF7F, 16'sh8000);
    send(hbs_pkg::FUNC_SAMPLE, 16'hFE80, 16'hFE80, 16'sh0000);
    send(hbs_pkg::FUNC_SAMPLE, 16'hFFFF, 16'hFFFF, 16'sh0000);
    drain();

    // random phases, each under its own grid size
    for (int p = 0; p < 8; p++) begin
      cols  = (p == 5) ? $urandom_range(1, 256) : phase_cols[p];
      nrows = (p == 6) ? $urandom_range(1, 256) : phase_rows[p];
      set_grid(hbs_pkg::CFG_W'(cols), hbs_pkg::CFG_W'(nrows));
      calm = (p % 3 == 0);
      ec = grid_model.eff_cols();
      er = grid_model.eff_rows();
      for (int i = 0; i < 250; i++) begin
        // move the working window now and then so writes and reads meet
        if (i % 64 == 0) begin
          span_x = (ec > 8) ? 8 : ec;
          span_y = (er > 8) ? 8 : er;
          base_x = (ec > span_x) ? $urandom_range(0, ec - span_x) : 0;
          base_y = (er > span_y) ? $urandom_range(0, er - span_y) : 0;
        end
        if (i % 100 == 50) calm = ~calm;
        send(($urandom_range(0, 99) < 45) ? hbs_pkg::FUNC_WRITE : hbs_pkg::FUNC_SAMPLE,
             pick_coord(base_x, span_x), pick_coord(base_y, span_y),
             pick_height());
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (grid_model.errors == 0 && grid_model.pending_heights.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
